[src/mtl_pkg.sv]
// ----------------------------------------------------------------------------
// mtl_pkg: shared definitions for the motion triggered logger
// Sizes, register indexes, codes and the record type of the log store.
// ----------------------------------------------------------------------------
package mtl_pkg;

    localparam int POINTS_PER_PACKET = 12;
    localparam int PACKETS           = 5;
    localparam int SLOTS             = POINTS_PER_PACKET * PACKETS;
    localparam int SLOT_W            = $clog2(SLOTS + 1);
    localparam int ADDR_W            = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int AXIS_W     = 16;
    localparam int LIGHT_W    = 24;
    localparam int ID_W       = 16;
    localparam int RSSI_W     = 8;
    localparam int MAG_W      = 16;
    localparam int LUX_W      = 16;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 8;
    localparam int RAD_W      = 2 * AXIS_W;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 72;

    // raw / 100 as (raw * ceil(2^31 / 100)) >> 31, exact for 24-bit raw
    localparam int LUX_RECIP_W = 25;
    localparam int LUX_SHIFT   = 31;
    localparam int LUXP_W      = LIGHT_W + LUX_RECIP_W;
    localparam int LUXQ_W      = LUXP_W - LUX_SHIFT;
    localparam logic [LUX_RECIP_W-1:0] LUX_RECIP = 25'd21474837;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_SAMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RSSI_LIM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID     = 3'd4;

    localparam logic [15:0] WAKE_THR_RST   = 16'd130;
    localparam logic [15:0] STILL_THR_RST  = 16'd110;
    localparam logic [7:0]  STILL_SAMP_RST = 8'd60;
    localparam logic [7:0]  RSSI_LIM_RST   = 8'hBA;   // -70
    localparam logic [15:0] OWN_ID_RST     = 16'd0;

    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_BEACON   = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_LOG    = 2'd1;
    localparam logic [1:0] PH_SETTLE = 2'd2;
    localparam logic [1:0] PH_DISC   = 2'd3;

    typedef struct packed {
        logic [LUX_W-1:0] lux;
        logic [MAG_W-1:0] motion;
    } rec_t;

endpackage

[src/mtl_isqrt.sv]
// ----------------------------------------------------------------------------
// mtl_isqrt: iterative integer square root
// Floor square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module mtl_isqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [mtl_pkg::RAD_W-1:0]  radicand,
    output logic                       done,
    output logic [mtl_pkg::MAG_W-1:0]  root
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [mtl_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [mtl_pkg::RAD_W-1:0]     rem_reg, rem_next;
    logic [mtl_pkg::RAD_W-1:0]     root_reg, root_next;
    logic [mtl_pkg::RAD_W-1:0]     bit_reg, bit_next;
    logic [mtl_pkg::RAD_W-1:0]     trial;

    assign trial = root_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = radicand;
            root_next = '0;
            bit_next  = {2'b01, {(mtl_pkg::RAD_W-2){1'b0}}};
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            step_next = step_reg + 1'b1;
            if (step_reg == mtl_pkg::STEP_W'(mtl_pkg::ROOT_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = root_reg[mtl_pkg::MAG_W-1:0];

endmodule

[src/mtl_store.sv]
// ----------------------------------------------------------------------------
// mtl_store: log record memory
// One write port, one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module mtl_store (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [mtl_pkg::ADDR_W-1:0]  waddr,
    input  mtl_pkg::rec_t               wdata,
    input  logic                        re,
    input  logic [mtl_pkg::ADDR_W-1:0]  raddr,
    output mtl_pkg::rec_t               rdata
);

    mtl_pkg::rec_t mem [mtl_pkg::SLOTS];
    mtl_pkg::rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/motion_triggered_logger_unit.sv]
// ----------------------------------------------------------------------------
// motion_triggered_logger_unit: motion triggered light and motion logger
// Wakes on motion, logs light and motion per sample, waits for stillness,
// then dumps the log on a matching beacon.
// ----------------------------------------------------------------------------
// channel  direction  contents
// s_*      in         sensor sample or beacon, opcode in s_tuser
// m_*      out        status result or log record, kind in m_tuser
// cfg_*    in         register writes, index 0..4
//
// A sample passes through the shared squaring multiplier, starts the root, runs
// the bit-per-cycle root loop (16 steps, then done), updates, loads the result
// and returns to idle before the next transfer in. A dump reads each record
// from memory, then loads it into the output register, held by any output stall.
// s_tready stays low until the result reaches the output register, so a stalled
// output holds off the next transfer in; aresetn is synchronous, log not cleared.
// ----------------------------------------------------------------------------
module motion_triggered_logger_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // accel_x, accel_y, accel_z, light_raw, light_error, beacon_dest,
    // beacon_src, rssi, zero pad
    input  logic [mtl_pkg::IN_DATA_W-1:0]   s_tdata,
    // opcode
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // phase, magnitude, record_index, light_lux, logged_motion, peer_id
    output logic [mtl_pkg::OUT_DATA_W-1:0]  m_tdata,
    // kind
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [mtl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    typedef struct packed {
        logic                       kind;
        logic [1:0]                 phase;
        logic [mtl_pkg::MAG_W-1:0]  mag;
        logic [mtl_pkg::IDX_W-1:0]  idx;
        logic [mtl_pkg::LUX_W-1:0]  lux;
        logic [mtl_pkg::MAG_W-1:0]  motion;
        logic [mtl_pkg::ID_W-1:0]   peer;
        logic                       last;
    } result_t;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_RGO   = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_BCN   = 3'd5;
    localparam logic [2:0] ST_RD    = 3'd6;
    localparam logic [2:0] ST_RDW   = 3'd7;

    // control state
    logic [2:0]                     state_reg, state_next;
    logic                           out_pend_reg, out_pend_next;
    logic [1:0]                     cnt_reg, cnt_next;
    logic [1:0]                     mode_reg, mode_next;
    logic [mtl_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [mtl_pkg::CNT_W-1:0]      still_reg, still_next;
    logic [mtl_pkg::LUX_W-1:0]      last_lux_reg, last_lux_next;
    logic [mtl_pkg::ADDR_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                           out_valid_reg, out_valid_next;

    // configuration
    logic [15:0]                    wake_thr_reg, wake_thr_next;
    logic [15:0]                    still_thr_reg, still_thr_next;
    logic [7:0]                     still_samp_reg, still_samp_next;
    logic [7:0]                     rssi_lim_reg, rssi_lim_next;
    logic [15:0]                    own_id_reg, own_id_next;

    // payload
    logic signed [mtl_pkg::AXIS_W-1:0] ax_reg, ay_reg, az_reg;
    logic [mtl_pkg::LIGHT_W-1:0]    light_reg;
    logic                           lerr_reg;
    logic [mtl_pkg::ID_W-1:0]       dest_reg, src_reg;
    logic [mtl_pkg::RSSI_W-1:0]     rssi_reg;
    logic [mtl_pkg::RAD_W-1:0]      prod_reg, prod_next;
    logic [mtl_pkg::RAD_W-1:0]      acc_reg, acc_next;
    logic [mtl_pkg::LUXQ_W-1:0]     luxq_reg, luxq_next;
    result_t                        res_reg, res_next;
    result_t                        out_reg, out_next;

    logic                           in_xfer;
    logic                           out_free;
    logic                           out_load;
    logic signed [mtl_pkg::AXIS_W-1:0]   axis_sel;
    logic signed [mtl_pkg::RAD_W-1:0]    sq;
    logic [mtl_pkg::LUXP_W-1:0]     lux_prod;
    logic [mtl_pkg::LUX_W-1:0]      lux_sat;
    logic [mtl_pkg::SLOT_W-1:0]     slot_inc;
    logic [mtl_pkg::CNT_W-1:0]      still_inc;

    logic                           root_start;
    logic                           root_done;
    logic [mtl_pkg::MAG_W-1:0]      mag;

    logic                           mem_we;
    mtl_pkg::rec_t                  mem_wdata;
    logic                           mem_re;
    mtl_pkg::rec_t                  mem_rdata;

    assign s_tready = (state_reg == ST_IDLE) && !out_pend_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // shared squaring multiplier, one axis per cycle
    always_comb begin
        case (cnt_reg)
            2'd0:    axis_sel = ax_reg;
            2'd1:    axis_sel = ay_reg;
            default: axis_sel = az_reg;
        endcase
    end
    assign sq       = mtl_pkg::RAD_W'(axis_sel) * mtl_pkg::RAD_W'(axis_sel);
    assign lux_prod = mtl_pkg::LUXP_W'(light_reg) * mtl_pkg::LUXP_W'(mtl_pkg::LUX_RECIP);
    assign lux_sat  = (luxq_reg > mtl_pkg::LUXQ_W'(16'hFFFF)) ? 16'hFFFF
                                                              : luxq_reg[mtl_pkg::LUX_W-1:0];
    assign slot_inc  = slot_reg + 1'b1;
    assign still_inc = still_reg + 1'b1;

    assign root_start = (state_reg == ST_RGO);

    mtl_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (acc_reg),
        .done     (root_done),
        .root     (mag)
    );

    mtl_store u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (slot_reg[mtl_pkg::ADDR_W-1:0]),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_idx_reg),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        out_pend_next   = out_pend_reg;
        cnt_next        = cnt_reg;
        mode_next       = mode_reg;
        slot_next       = slot_reg;
        still_next      = still_reg;
        last_lux_next   = last_lux_reg;
        rd_idx_next     = rd_idx_reg;
        wake_thr_next   = wake_thr_reg;
        still_thr_next  = still_thr_reg;
        still_samp_next = still_samp_reg;
        rssi_lim_next   = rssi_lim_reg;
        own_id_next     = own_id_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        luxq_next       = luxq_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = '0;
        mem_re          = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                mtl_pkg::REG_WAKE_THR:   wake_thr_next   = cfg_wdata;
                mtl_pkg::REG_STILL_THR:  still_thr_next  = cfg_wdata;
                mtl_pkg::REG_STILL_SAMP: still_samp_next = cfg_wdata[7:0];
                mtl_pkg::REG_RSSI_LIM:   rssi_lim_next   = cfg_wdata[7:0];
                mtl_pkg::REG_OWN_ID:     own_id_next     = cfg_wdata;
                default: ;
            endcase
        end

        // pending status result waits here for the output register
        if (out_pend_reg && out_free) begin
            out_next      = res_reg;
            out_load      = 1'b1;
            out_pend_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cnt_next = '0;
                    acc_next = '0;
                    if (s_tuser == mtl_pkg::OP_SAMPLE) begin
                        state_next = ST_SQ;
                    end else begin
                        state_next = ST_BCN;
                    end
                end
            end
            ST_SQ: begin
                // product of axis n lands while axis n-1 is accumulated
                if (cnt_reg != 2'd3) begin
                    prod_next = unsigned'(sq);
                end
                if (cnt_reg != 2'd0) begin
                    acc_next = acc_reg + prod_reg;
                end else begin
                    luxq_next = lux_prod[mtl_pkg::LUXP_W-1:mtl_pkg::LUX_SHIFT];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd3) begin
                    state_next = ST_RGO;
                end
            end
            ST_RGO: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                case (mode_reg)
                    mtl_pkg::PH_WAIT: begin
                        if (mag >= wake_thr_reg) begin
                            mode_next = mtl_pkg::PH_LOG;
                            slot_next = '0;
                        end
                    end
                    mtl_pkg::PH_LOG: begin
                        if (!lerr_reg) begin
                            last_lux_next = lux_sat;
                        end
                        if (slot_reg < mtl_pkg::SLOT_W'(mtl_pkg::SLOTS)) begin
                            mem_we           = 1'b1;
                            mem_wdata.lux    = last_lux_next;
                            mem_wdata.motion = mag;
                        end
                        slot_next = slot_inc;
                        if (slot_inc >= mtl_pkg::SLOT_W'(mtl_pkg::SLOTS)) begin
                            mode_next  = mtl_pkg::PH_SETTLE;
                            still_next = '0;
                        end
                    end
                    mtl_pkg::PH_SETTLE: begin
                        if (mag < still_thr_reg) begin
                            still_next = still_inc;
                            if (still_inc >= still_samp_reg) begin
                                mode_next = mtl_pkg::PH_DISC;
                            end
                        end else begin
                            still_next = '0;
                        end
                    end
                    default: ;
                endcase
                res_next       = '0;
                res_next.kind  = mtl_pkg::KIND_STATUS;
                res_next.phase = mode_next;
                res_next.mag   = mag;
                res_next.last  = 1'b1;
                out_pend_next  = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_BCN: begin
                if (mode_reg == mtl_pkg::PH_DISC && dest_reg == own_id_reg &&
                    $signed(rssi_reg) >= $signed(rssi_lim_reg)) begin
                    rd_idx_next = '0;
                    state_next  = ST_RD;
                end else begin
                    res_next       = '0;
                    res_next.kind  = mtl_pkg::KIND_STATUS;
                    res_next.phase = mode_reg;
                    res_next.last  = 1'b1;
                    out_pend_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RD: begin
                mem_re     = 1'b1;
                state_next = ST_RDW;
            end
            ST_RDW: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_next.kind   = mtl_pkg::KIND_RECORD;
                    out_next.phase  = mtl_pkg::PH_DISC;
                    out_next.mag    = '0;
                    out_next.idx    = mtl_pkg::IDX_W'(rd_idx_reg);
                    out_next.lux    = mem_rdata.lux;
                    out_next.motion = mem_rdata.motion;
                    out_next.peer   = src_reg;
                    out_next.last   = (rd_idx_reg == mtl_pkg::ADDR_W'(mtl_pkg::SLOTS - 1));
                    if (rd_idx_reg == mtl_pkg::ADDR_W'(mtl_pkg::SLOTS - 1)) begin
                        mode_next  = mtl_pkg::PH_WAIT;
                        slot_next  = '0;
                        still_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            out_pend_reg   <= 1'b0;
            cnt_reg        <= '0;
            mode_reg       <= mtl_pkg::PH_WAIT;
            slot_reg       <= '0;
            still_reg      <= '0;
            last_lux_reg   <= '0;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
            wake_thr_reg   <= mtl_pkg::WAKE_THR_RST;
            still_thr_reg  <= mtl_pkg::STILL_THR_RST;
            still_samp_reg <= mtl_pkg::STILL_SAMP_RST;
            rssi_lim_reg   <= mtl_pkg::RSSI_LIM_RST;
            own_id_reg     <= mtl_pkg::OWN_ID_RST;
        end else begin
            state_reg      <= state_next;
            out_pend_reg   <= out_pend_next;
            cnt_reg        <= cnt_next;
            mode_reg       <= mode_next;
            slot_reg       <= slot_next;
            still_reg      <= still_next;
            last_lux_reg   <= last_lux_next;
            rd_idx_reg     <= rd_idx_next;
            out_valid_reg  <= out_valid_next;
            wake_thr_reg   <= wake_thr_next;
            still_thr_reg  <= still_thr_next;
            still_samp_reg <= still_samp_next;
            rssi_lim_reg   <= rssi_lim_next;
            own_id_reg     <= own_id_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            ax_reg    <= s_tdata[15:0];
            ay_reg    <= s_tdata[31:16];
            az_reg    <= s_tdata[47:32];
            light_reg <= s_tdata[71:48];
            lerr_reg  <= s_tdata[72];
            dest_reg  <= s_tdata[88:73];
            src_reg   <= s_tdata[104:89];
            rssi_reg  <= s_tdata[112:105];
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        luxq_reg <= luxq_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {out_reg.peer, out_reg.motion, out_reg.lux,
                       out_reg.idx, out_reg.mag, out_reg.phase};

endmodule

[src/mtl_checker.sv]
// ----------------------------------------------------------------------------
// mtl_checker: port level checks for the motion triggered logger
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module mtl_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mtl_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // a status result is always the final one of its input
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mtl_pkg::KIND_STATUS |-> m_tlast)
        else $error("status result without last");

    // records only come out of discovery and carry no magnitude
    a_record_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mtl_pkg::KIND_RECORD |->
            m_tdata[1:0] == mtl_pkg::PH_DISC && m_tdata[17:2] == 16'd0)
        else $error("record with bad phase or magnitude");

    // status results leave the record fields clear
    a_status_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mtl_pkg::KIND_STATUS |-> m_tdata[71:18] == '0)
        else $error("status result with record fields set");

endmodule

bind motion_triggered_logger_unit mtl_checker u_mtl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[bench/motion_triggered_logger_unit_tb.sv]
// ----------------------------------------------------------------------------
// motion_triggered_logger_unit_tb: self-checking bench for the motion logger
// Drives samples and beacons on the input stream, predicts every status and
// log record in a scoreboard, and checks the output stream field by field
// under several handshake mixes, register settings and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motion_triggered_logger_unit_tb;

    localparam int     HALF_NS          = 10;
    localparam longint LIMIT_NS         = 10_000_000;
    localparam int     RESET_CYCLES     = 11;
    localparam int     DRAIN_CYCLES     = 40;
    localparam int     HOLD_CYCLES      = 500;
    localparam int     RANDOM_PER_PHASE = 80;
    localparam int     REPORT_LIMIT     = 10;

    typedef struct packed {
        logic        op;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic [23:0] light;
        logic        lerr;
        logic [15:0] dest;
        logic [15:0] src;
        logic [7:0]  rssi;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  phase;
        logic [15:0] mag;
        logic [5:0]  idx;
        logic [15:0] lux;
        logic [15:0] mot;
        logic [15:0] peer;
        logic        last;
    } result_t;

    // mirror of the logger: registers, phase state, log store and the
    // queue of results still owed by the block
    class logger_scoreboard;
        logic [15:0] wake_thr;
        logic [15:0] still_thr;
        logic [7:0]  still_need;
        logic [7:0]  rssi_floor;
        logic [15:0] own_id;
        logic [1:0]  mode;
        int unsigned slot_cnt;
        logic [7:0]  still_cnt;
        logic [15:0] held_lux;
        logic [15:0] lux_log [mtl_pkg::SLOTS];
        logic [15:0] motion_log [mtl_pkg::SLOTS];
        result_t     pending_results [$];
        int          fails;
        int          samples;
        int          beacons;
        int          statuses;
        int          dumps;

        function new();
            wake_thr   = mtl_pkg::WAKE_THR_RST;
            still_thr  = mtl_pkg::STILL_THR_RST;
            still_need = mtl_pkg::STILL_SAMP_RST;
            rssi_floor = mtl_pkg::RSSI_LIM_RST;
            own_id     = mtl_pkg::OWN_ID_RST;
            mode       = mtl_pkg::PH_WAIT;
            slot_cnt   = 0;
            still_cnt  = '0;
            held_lux   = '0;
        endfunction

        function void write_reg(logic [mtl_pkg::CFG_IDX_W-1:0] idx,
                                logic [mtl_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                mtl_pkg::REG_WAKE_THR:   wake_thr   = val;
                mtl_pkg::REG_STILL_THR:  still_thr  = val;
                mtl_pkg::REG_STILL_SAMP: still_need = val[7:0];
                mtl_pkg::REG_RSSI_LIM:   rssi_floor = val[7:0];
                mtl_pkg::REG_OWN_ID:     own_id     = val;
                default: ;
            endcase
        endfunction

        // digit-by-digit floor square root
        function logic [15:0] floor_root(longint unsigned n);
            longint unsigned root;
            longint unsigned b;
            root = 0;
            b = 64'd1 << 32;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= root + b) begin
                    n -= root + b;
                    root = (root >> 1) + b;
                end else begin
                    root >>= 1;
                end
                b >>= 2;
            end
            return root[15:0];
        endfunction

        function void accept_item(item_t it);
            int              x;
            int              y;
            int              z;
            longint unsigned sq;
            logic [15:0]     mag;
            int unsigned     q;
            result_t         r;
            r = '0;
            if (it.op == mtl_pkg::OP_SAMPLE) begin
                samples++;
                x = $signed(it.ax);
                y = $signed(it.ay);
                z = $signed(it.az);
                sq = longint'(x) * x + longint'(y) * y + longint'(z) * z;
                mag = floor_root(sq);
                case (mode)
                    mtl_pkg::PH_WAIT: begin
                        if (mag >= wake_thr) begin
                            mode = mtl_pkg::PH_LOG;
                            slot_cnt = 0;
                        end
                    end
                    mtl_pkg::PH_LOG: begin
                        if (!it.lerr) begin
                            q = it.light / 100;
                            held_lux = (q > 65535) ? 16'hFFFF : q[15:0];
                        end
                        if (slot_cnt < mtl_pkg::SLOTS) begin
                            lux_log[slot_cnt] = held_lux;
                            motion_log[slot_cnt] = mag;
                        end
                        slot_cnt++;
                        if (slot_cnt >= mtl_pkg::SLOTS) begin
                            mode = mtl_pkg::PH_SETTLE;
                            still_cnt = '0;
                        end
                    end
                    mtl_pkg::PH_SETTLE: begin
                        if (mag < still_thr) begin
                            still_cnt = still_cnt + 8'd1;
                            if (still_cnt >= still_need) mode = mtl_pkg::PH_DISC;
                        end else begin
                            still_cnt = '0;
                        end
                    end
                    default: ;
                endcase
                r.mag = mag;
            end else begin
                beacons++;
                if (mode == mtl_pkg::PH_DISC && it.dest == own_id &&
                    $signed(it.rssi) >= $signed(rssi_floor)) begin
                    for (int k = 0; k < mtl_pkg::SLOTS; k++) begin
                        r = '0;
                        r.kind  = mtl_pkg::KIND_RECORD;
                        r.phase = mtl_pkg::PH_DISC;
                        r.idx   = 6'(k);
                        r.lux   = lux_log[k];
                        r.mot   = motion_log[k];
                        r.peer  = it.src;
                        r.last  = (k == mtl_pkg::SLOTS - 1);
                        pending_results.push_back(r);
                    end
                    mode = mtl_pkg::PH_WAIT;
                    slot_cnt = 0;
                    still_cnt = '0;
                    dumps++;
                    return;
                end
            end
            r.kind  = mtl_pkg::KIND_STATUS;
            r.phase = mode;
            r.last  = 1'b1;
            statuses++;
            pending_results.push_back(r);
        endfunction

        function string show(result_t r);
            return $sformatf("kind=%0d phase=%0d mag=%0d idx=%0d lux=%0d mot=%0d peer=%h last=%0d",
                             r.kind, r.phase, r.mag, r.idx, r.lux, r.mot, r.peer, r.last);
        endfunction

        function void note_failure(string msg);
            fails++;
            if (fails <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function void check_result(result_t got);
            result_t want;
            string   diff;
            if (pending_results.size() == 0) begin
                note_failure({"result with nothing pending: ", show(got)});
                return;
            end
            want = pending_results.pop_front();
            diff = "";
            if (got.kind  !== want.kind)  diff = {diff, " kind"};
            if (got.phase !== want.phase) diff = {diff, " phase"};
            if (got.mag   !== want.mag)   diff = {diff, " magnitude"};
            if (got.idx   !== want.idx)   diff = {diff, " record_index"};
            if (got.lux   !== want.lux)   diff = {diff, " light_lux"};
            if (got.mot   !== want.mot)   diff = {diff, " logged_motion"};
            if (got.peer  !== want.peer)  diff = {diff, " peer_id"};
            if (got.last  !== want.last)  diff = {diff, " last"};
            if (diff != "")
                note_failure($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                                       diff, show(want), show(got)));
        endfunction

        function void finish_check();
            if (pending_results.size() != 0)
                note_failure($sformatf("%0d expected results never arrived",
                                       pending_results.size()));
        endfunction
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [mtl_pkg::IN_DATA_W-1:0]      s_tdata;
    logic                               s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [mtl_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic                               m_tuser;
    logic                               m_tlast;
    logic                               cfg_we;
    logic [mtl_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [mtl_pkg::CFG_DATA_W-1:0]     cfg_wdata;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    logger_scoreboard sb;

    motion_triggered_logger_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #(HALF_NS);
        aclk = 1'b1;
        #(HALF_NS);
    end

    // receiver: long hold-off first if requested, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : take_result
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = m_tuser;
            got.phase = m_tdata[1:0];
            got.mag   = m_tdata[17:2];
            got.idx   = m_tdata[23:18];
            got.lux   = m_tdata[39:24];
            got.mot   = m_tdata[55:40];
            got.peer  = m_tdata[71:56];
            got.last  = m_tlast;
            sb.check_result(got);
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout, %0d results still pending", sb.pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------
    function automatic item_t random_item();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(item_t)-1:0];
    endfunction

    function automatic logic [15:0] with_sign(int v);
        return $urandom_range(1) ? 16'(v) : 16'(-v);
    endfunction

    function automatic item_t sample_base();
        item_t it;
        it = random_item();
        it.op = mtl_pkg::OP_SAMPLE;
        it.lerr = ($urandom_range(9) == 0);
        // keep most readings in range so the divide is exercised, not just saturation
        if ($urandom_range(4) != 0) it.light = 24'($urandom_range(6553599));
        return it;
    endfunction

    // magnitude at or above thr where the axes allow it
    function automatic item_t moving_sample(int thr);
        item_t it;
        it = sample_base();
        if ($urandom_range(3) == 0) begin
            it.ax = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            it.ay = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            it.az = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        end else if (thr <= 32767) begin
            it.ax = with_sign($urandom_range(32767, thr));
        end else begin
            it.ax = with_sign($urandom_range(32767, 32000));
            it.ay = with_sign($urandom_range(32767, 32000));
            it.az = with_sign($urandom_range(32767, 32000));
        end
        return it;
    endfunction

    // magnitude below thr: each axis within (thr-1)/2 keeps sqrt(3)*r < thr
    function automatic item_t still_sample(int thr);
        item_t it;
        int    r;
        it = sample_base();
        r = (thr > 0) ? (thr - 1) / 2 : 0;
        if (r > 32767) r = 32767;
        it.ax = 16'(int'($urandom_range(2 * r)) - r);
        it.ay = 16'(int'($urandom_range(2 * r)) - r);
        it.az = 16'(int'($urandom_range(2 * r)) - r);
        return it;
    endfunction

    function automatic item_t beacon_item(logic [15:0] dest, logic [7:0] rssi);
        item_t it;
        it = random_item();
        it.op = mtl_pkg::OP_BEACON;
        it.dest = dest;
        it.rssi = rssi;
        return it;
    endfunction

    function automatic item_t mk_sample(int x, int y, int z, int light, bit err);
        item_t it;
        it = '0;
        it.op = mtl_pkg::OP_SAMPLE;
        it.ax = 16'(x);
        it.ay = 16'(y);
        it.az = 16'(z);
        it.light = 24'(light);
        it.lerr = err;
        return it;
    endfunction

    function automatic item_t mk_beacon(int dest, int src, int rssi);
        item_t it;
        it = '0;
        it.op = mtl_pkg::OP_BEACON;
        it.dest = 16'(dest);
        it.src = 16'(src);
        it.rssi = 8'(rssi);
        return it;
    endfunction

    // next item of a well-formed wake / log / settle / discover session
    function automatic item_t session_item();
        int          lim;
        int          pick;
        logic [7:0]  good;
        lim = $signed(sb.rssi_floor);
        good = 8'(lim + int'($urandom_range(127 - lim)));
        case (sb.mode)
            mtl_pkg::PH_WAIT:
                return ($urandom_range(4) == 0) ? still_sample(sb.wake_thr)
                                                : moving_sample(sb.wake_thr);
            mtl_pkg::PH_LOG: begin
                if ($urandom_range(19) == 0) return beacon_item(16'($urandom), 8'($urandom));
                return $urandom_range(1) ? moving_sample($urandom_range(56000))
                                         : still_sample($urandom_range(2000));
            end
            mtl_pkg::PH_SETTLE:
                return ($urandom_range(6) == 0) ? moving_sample(sb.still_thr)
                                                : still_sample(sb.still_thr);
            default: begin
                pick = $urandom_range(9);
                if (pick < 2)
                    return beacon_item(sb.own_id ^ 16'($urandom_range(65535, 1)), good);
                if (pick == 2 && lim > -128)
                    return beacon_item(sb.own_id, 8'(lim - 1 - int'($urandom_range(lim + 127))));
                if (pick == 3) return still_sample(sb.still_thr);
                return beacon_item(sb.own_id, good);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_item(input item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.op;
        s_tdata  = {7'b0, it.rssi, it.src, it.dest, it.lerr, it.light, it.az, it.ay, it.ax};
        do @(posedge aclk); while (!s_tready);
        sb.accept_item(it);
    endtask

    task automatic write_reg(input logic [mtl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mtl_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // upper bits of the narrow registers carry junk that must be dropped
    task automatic configure(input int wake, input int still_thr, input int still_n,
                             input int rssi, input int id);
        write_reg(mtl_pkg::REG_WAKE_THR, 16'(wake));
        write_reg(mtl_pkg::REG_STILL_THR, 16'(still_thr));
        write_reg(mtl_pkg::REG_STILL_SAMP, {8'($urandom), 8'(still_n)});
        write_reg(mtl_pkg::REG_RSSI_LIM, {8'($urandom), 8'(rssi)});
        write_reg(mtl_pkg::REG_OWN_ID, 16'(id));
        write_reg(mtl_pkg::CFG_IDX_W'($urandom_range(7, 5)), 16'($urandom));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int count);
        for (int i = 0; i < count; i++)
            send_item(($urandom_range(99) < 12) ? random_item() : session_item());
        drain();
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // axis extremes and beacons while nothing can wake the logger
        write_reg(mtl_pkg::REG_WAKE_THR, 16'hFFFF);
        send_item(mk_sample(0, 0, 0, 0, 1'b0));
        send_item(mk_sample(-32768, -32768, -32768, 24'hFFFFFF, 1'b0));
        send_item(mk_sample(32767, 32767, 32767, 100, 1'b1));
        send_item(mk_sample(-32768, 32767, 0, 12345, 1'b0));
        send_item(mk_beacon(0, 16'hFFFF, 127));
        send_item(mk_beacon(16'hFFFF, 0, -128));
        drain();

        // wake exactly at threshold, then light rounding, saturation and errors
        write_reg(mtl_pkg::REG_WAKE_THR, 16'd130);
        send_item(mk_sample(100, 0, 0, 500, 1'b0));
        send_item(mk_sample(0, -130, 0, 500, 1'b0));
        send_item(mk_sample(1, 2, 3, 24'hFFFFFF, 1'b0));
        send_item(mk_sample(-32768, -32768, -32768, 0, 1'b1));
        send_item(mk_sample(32767, -32768, 32767, 6553599, 1'b0));
        send_item(mk_sample(0, 0, 0, 6553600, 1'b0));
        send_item(mk_sample(5, 5, 5, 99, 1'b0));
        send_item(mk_sample(5, 5, 5, 100, 1'b0));
        send_item(mk_beacon(0, 16'h1234, 127));
        send_item(mk_sample(0, 0, 0, 0, 1'b1));
        drain();

        // no idling; output held off long enough to back up the input
        configure(0, 65535, 0, -128, 0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        run_phase(RANDOM_PER_PHASE);

        configure(200, 300, 4, 0, 16'hFFFF);
        send_idle_pct  = 88;
        recv_stall_pct = 0;
        run_phase(RANDOM_PER_PHASE);

        configure(50000, 1, 255, -1, 16'hA5A5);
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        run_phase(RANDOM_PER_PHASE);

        configure(40000, 5000, 2, -70, 16'h0001);
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        run_phase(RANDOM_PER_PHASE);

        sb.finish_check();
        $display("covered %0d samples and %0d beacons under four handshake mixes",
                 sb.samples, sb.beacons);
        $display("checked %0d status transfers and %0d log dumps of %0d records, %0d failures",
                 sb.statuses, sb.dumps, mtl_pkg::SLOTS, sb.fails);
        if (sb.fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
src/mtl_pkg.sv
src/mtl_isqrt.sv
src/mtl_store.sv
src/motion_triggered_logger_unit.sv
src/mtl_checker.sv
bench/motion_triggered_logger_unit_tb.sv
